>>> sv/calibration_table_interpolator_unit_macros.svh
// Assertion macros for the calibration table interpolator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calibration table interpolator: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calibration table interpolator: check failed");

`endif

>>> sv/cti_pkg.sv
package cti_pkg;

    // Table geometry.
    localparam int MAX_POINTS = 16;
    localparam int NUM_TABLES = 3;
    localparam int DEPTH      = NUM_TABLES * MAX_POINTS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths.
    localparam int REQ_W      = 1;
    localparam int TSEL_W     = 2;
    localparam int PIDX_W     = 4;
    localparam int VOLT_W     = 12;
    localparam int TEMP_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;

    // Arithmetic widths.
    localparam int DY_W       = TEMP_W + 1;
    localparam int DX_W       = VOLT_W + 1;
    localparam int PROD_W     = DY_W + DX_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int SUM_W      = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((2 ** (TEMP_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD    = 1'b0;
    localparam logic [REQ_W-1:0] REQ_CONVERT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WATER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERTEMP = 2'd2;

    // Table select codes.
    localparam logic [TSEL_W-1:0] TSEL_WATER = 2'd0;
    localparam logic [TSEL_W-1:0] TSEL_FLAME = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_INTERP = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EXT_LO = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXT_HI = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ZERO   = 3'd4;

    // One calibration point as stored in the table memory.
    typedef struct packed {
        logic [VOLT_W-1:0]        volt;
        logic signed [TEMP_W-1:0] temp;
    } point_t;

    // Divider request and response.
    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic signed [DX_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/cti_interfaces.sv
// Request channel: load a point or convert a sample.
interface cti_req_if;
    import cti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [TSEL_W-1:0]        table_select;
    logic [PIDX_W-1:0]        point_index;
    logic [VOLT_W-1:0]        point_voltage;
    logic signed [TEMP_W-1:0] point_temperature;
    logic [VOLT_W-1:0]        raw_sample;

    modport source (
        output valid, req_type, table_select, point_index,
               point_voltage, point_temperature, raw_sample,
        input  ready
    );

    modport sink (
        input  valid, req_type, table_select, point_index,
               point_voltage, point_temperature, raw_sample,
        output ready
    );
endinterface

// Result channel: one converted temperature.
interface cti_res_if;
    import cti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic [STATUS_W-1:0]      status;
    logic                     saturated;

    modport source (
        output valid, temperature, status, saturated,
        input  ready
    );

    modport sink (
        input  valid, temperature, status, saturated,
        output ready
    );
endinterface

>>> sv/cti_point_mem.sv
module cti_point_mem (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [cti_pkg::ADDR_W-1:0] wr_addr,
    input  cti_pkg::point_t            wr_data,
    input  logic                       rd_en,
    input  logic [cti_pkg::ADDR_W-1:0] rd_addr,
    output cti_pkg::point_t            rd_data
);
    import cti_pkg::*;

    point_t mem_array [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

>>> sv/cti_divider.sv
module cti_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cti_pkg::div_req_t div_req,
    output cti_pkg::div_rsp_t div_rsp
);
    import cti_pkg::*;

    localparam int DVS_W  = VOLT_W;
    localparam int STEP_W = $clog2(MAG_W + 1);

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0]           shifted;
    logic signed [PROD_W-1:0] dividend_abs;
    logic signed [DX_W-1:0]   divisor_abs;

    // Restoring division, one quotient bit per cycle on magnitudes.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        dividend_abs = div_req.dividend[PROD_W-1] ? -div_req.dividend : div_req.dividend;
        divisor_abs  = div_req.divisor[DX_W-1] ? -div_req.divisor : div_req.divisor;
        shifted      = {rem_reg, quo_reg[MAG_W-1]};

        if (div_req.start)
        begin
            rem_next  = '0;
            quo_next  = dividend_abs[MAG_W-1:0];
            dvs_next  = divisor_abs[DVS_W-1:0];
            neg_next  = div_req.dividend[PROD_W-1] ^ div_req.divisor[DX_W-1];
            cnt_next  = STEP_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Truncation toward zero: negate the magnitude quotient when signs differ.
    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

>>> sv/calibration_table_interpolator_unit.sv
// Convert steps, from accept to result valid: point reads and compares over the table's point count,
// one multiply, one divider start, 29 quotient bits, one hand-off and one result load; early matches
// and zero widths end sooner. Flow: a load gives no result; one convert at a time, and loads are
// taken while a finished result still waits.
// Reset: point counts return to 2, result channel empties, table contents stay undefined.
`include "calibration_table_interpolator_unit_macros.svh"

module calibration_table_interpolator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    cti_req_if.sink                       req,
    cti_res_if.source                     res,
    input  logic                          cfg_wr_en,
    input  logic [cti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cti_pkg::CFG_W-1:0]     cfg_data
);
    import cti_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [CFG_W-1:0] water_points_reg;
    logic [CFG_W-1:0] flame_points_reg;
    logic [CFG_W-1:0] overtemp_points_reg;

    logic [VOLT_W-1:0]        s_reg, s_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    point_t                   p0_reg, p0_next;
    point_t                   p1_reg, p1_next;
    point_t                   prev_reg, prev_next;
    point_t                   seg_a_reg, seg_a_next;
    point_t                   seg_b_reg, seg_b_next;
    logic [STATUS_W-1:0]      stat_reg, stat_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DX_W-1:0]   dx_reg, dx_next;
    logic signed [TEMP_W-1:0] rtemp_reg, rtemp_next;
    logic [STATUS_W-1:0]      rstat_reg, rstat_next;
    logic                     rsat_reg, rsat_next;

    logic                     res_valid_reg, res_valid_next;
    logic signed [TEMP_W-1:0] res_temp_reg, res_temp_next;
    logic [STATUS_W-1:0]      res_stat_reg, res_stat_next;
    logic                     res_sat_reg, res_sat_next;

    logic              req_fire;
    logic              out_free;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    point_t            mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    point_t            mem_rd_data;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [CFG_W-1:0]         cnt_raw;
    logic [CNT_W-1:0]         cnt_clamped;
    logic [ADDR_W-1:0]        req_base;
    logic                     idx_last;
    point_t                   p1_eff;
    logic signed [PROD_W-1:0] dy_ext;
    logic signed [PROD_W-1:0] ds_ext;
    logic signed [SUM_W-1:0]  sum;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !res_valid_reg || res.ready;

    // Point loads go straight into the table memory.
    assign mem_wr_en   = req_fire && (req.req_type == REQ_LOAD)
                         && (32'(req.table_select) < 32'(NUM_TABLES))
                         && (32'(req.point_index) < 32'(MAX_POINTS));
    assign req_base    = ADDR_W'(int'(req.table_select) * MAX_POINTS);
    assign mem_wr_addr = req_base + ADDR_W'(req.point_index);
    assign mem_wr_data = '{volt: req.point_voltage, temp: req.point_temperature};
    assign mem_rd_en   = (state_reg == ST_READ);
    assign mem_rd_addr = base_reg + ADDR_W'(idx_reg);

    cti_point_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign div_req.start    = (state_reg == ST_DIV);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = dx_reg;

    cti_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Point count of the selected table, held between two and the table size.
    always_comb
    begin
        case (req.table_select)
            TSEL_WATER: cnt_raw = water_points_reg;
            TSEL_FLAME: cnt_raw = flame_points_reg;
            default:    cnt_raw = overtemp_points_reg;
        endcase
        if (cnt_raw < CFG_W'(2))
        begin
            cnt_clamped = CNT_W'(2);
        end
        else if (32'(cnt_raw) > 32'(MAX_POINTS))
        begin
            cnt_clamped = CNT_W'(MAX_POINTS);
        end
        else
        begin
            cnt_clamped = CNT_W'(cnt_raw);
        end
    end

    // Segment search, multiply and result sequencing.
    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        base_next      = base_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        prev_next      = prev_reg;
        seg_a_next     = seg_a_reg;
        seg_b_next     = seg_b_reg;
        stat_next      = stat_reg;
        prod_next      = prod_reg;
        dx_next        = dx_reg;
        rtemp_next     = rtemp_reg;
        rstat_next     = rstat_reg;
        rsat_next      = rsat_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_temp_next  = res_temp_reg;
        res_stat_next  = res_stat_reg;
        res_sat_next   = res_sat_reg;

        idx_last = (CNT_W'(idx_reg) == n_reg - CNT_W'(1));
        p1_eff   = (idx_reg == IDX_W'(1)) ? mem_rd_data : p1_reg;
        dy_ext   = PROD_W'(seg_b_reg.temp) - PROD_W'(seg_a_reg.temp);
        ds_ext   = $signed(PROD_W'(s_reg)) - $signed(PROD_W'(seg_a_reg.volt));
        sum      = SUM_W'(seg_a_reg.temp) + SUM_W'(div_rsp.quotient);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_CONVERT))
                begin
                    if (32'(req.table_select) < 32'(NUM_TABLES))
                    begin
                        s_next     = req.raw_sample;
                        base_next  = req_base;
                        n_next     = cnt_clamped;
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        rtemp_next = '0;
                        rstat_next = STAT_NONE;
                        rsat_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    p0_next    = mem_rd_data;
                    prev_next  = mem_rd_data;
                    idx_next   = IDX_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    if (idx_reg == IDX_W'(1))
                    begin
                        p1_next = mem_rd_data;
                    end
                    if ((s_reg >= prev_reg.volt) && (s_reg <= mem_rd_data.volt))
                    begin
                        seg_a_next = prev_reg;
                        seg_b_next = mem_rd_data;
                        stat_next  = STAT_INTERP;
                        state_next = ST_MUL;
                    end
                    else if (idx_last)
                    begin
                        if (s_reg < p0_reg.volt)
                        begin
                            seg_a_next = p0_reg;
                            seg_b_next = p1_eff;
                            stat_next  = STAT_EXT_LO;
                            state_next = ST_MUL;
                        end
                        else if (s_reg > mem_rd_data.volt)
                        begin
                            seg_a_next = prev_reg;
                            seg_b_next = mem_rd_data;
                            stat_next  = STAT_EXT_HI;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            rtemp_next = '0;
                            rstat_next = STAT_NONE;
                            rsat_next  = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        prev_next  = mem_rd_data;
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_MUL:
            begin
                if (seg_a_reg.volt == seg_b_reg.volt)
                begin
                    rtemp_next = seg_a_reg.temp;
                    rstat_next = STAT_ZERO;
                    rsat_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    prod_next  = dy_ext * ds_ext;
                    dx_next    = $signed({1'b0, seg_b_reg.volt})
                                 - $signed({1'b0, seg_a_reg.volt});
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rstat_next = stat_reg;
                    if (sum > SUM_MAX)
                    begin
                        rtemp_next = TEMP_W'(SUM_MAX);
                        rsat_next  = 1'b1;
                    end
                    else if (sum < SUM_MIN)
                    begin
                        rtemp_next = TEMP_W'(SUM_MIN);
                        rsat_next  = 1'b1;
                    end
                    else
                    begin
                        rtemp_next = sum[TEMP_W-1:0];
                        rsat_next  = 1'b0;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_temp_next  = rtemp_reg;
                    res_stat_next  = rstat_reg;
                    res_sat_next   = rsat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            res_valid_reg       <= 1'b0;
            idx_reg             <= '0;
            n_reg               <= CNT_W'(2);
            water_points_reg    <= CFG_W'(2);
            flame_points_reg    <= CFG_W'(2);
            overtemp_points_reg <= CFG_W'(2);
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_WATER:    water_points_reg    <= cfg_data;
                    CFG_FLAME:    flame_points_reg    <= cfg_data;
                    CFG_OVERTEMP: overtemp_points_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        base_reg     <= base_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        prev_reg     <= prev_next;
        seg_a_reg    <= seg_a_next;
        seg_b_reg    <= seg_b_next;
        stat_reg     <= stat_next;
        prod_reg     <= prod_next;
        dx_reg       <= dx_next;
        rtemp_reg    <= rtemp_next;
        rstat_reg    <= rstat_next;
        rsat_reg     <= rsat_next;
        res_temp_reg <= res_temp_next;
        res_stat_reg <= res_stat_next;
        res_sat_reg  <= res_sat_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.temperature = res_temp_reg;
    assign res.status      = res_stat_reg;
    assign res.saturated   = res_sat_reg;

    // The divider only finishes while the sequencer waits for it.
    `CTI_ASSERT_IMPL(a_div_done_in_wait, div_rsp.done, state_reg == ST_WAIT)
    // An accepted convert transaction always starts work.
    `CTI_ASSERT_NEXT(a_convert_leaves_idle, req_fire && (req.req_type == REQ_CONVERT), !req.ready)
    // A new result appears only out of the result state.
    `CTI_ASSERT_IMPL(a_result_from_done, $rose(res_valid_reg), $past(state_reg) == ST_DONE)
    // The search never reads past the last point in use.
    `CTI_ASSERT_IMPL(a_idx_in_range, state_reg == ST_CHECK, CNT_W'(idx_reg) < n_reg)

endmodule

>>> bench/tb_calibration_table_interpolator_unit.sv
`timescale 1ns / 1ps

module tb_calibration_table_interpolator_unit;
    import cti_pkg::*;

    // Table selects the package leaves unnamed.
    localparam logic [TSEL_W-1:0] TSEL_OVERTEMP = 2'd2;
    localparam logic [TSEL_W-1:0] TSEL_UNUSED   = 2'd3;

    // Long enough to cover any work still in flight.
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_LIMIT     = 20000;

    typedef enum int {
        LAYOUT_SORTED,
        LAYOUT_STEEP,
        LAYOUT_SHUFFLED
    } table_layout_t;

    typedef struct {
        logic [REQ_W-1:0]         kind;
        logic [TSEL_W-1:0]        tsel;
        logic [PIDX_W-1:0]        idx;
        logic [VOLT_W-1:0]        volt;
        logic signed [TEMP_W-1:0] temp;
        logic [VOLT_W-1:0]        sample;
    } cal_request_t;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [STATUS_W-1:0]      status;
        logic                     sat;
    } temp_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cti_req_if req_ch ();
    cti_res_if res_ch ();

    calibration_table_interpolator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the calibration tables and point counts.
    logic [VOLT_W-1:0]        cal_volt [DEPTH];
    logic signed [TEMP_W-1:0] cal_temp [DEPTH];
    logic [CFG_W-1:0]         cal_count [NUM_TABLES];

    temp_result_t pending_temps [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_seq;
    int mismatch_count;

    always #1 clk = ~clk;

    task automatic flag_mismatch(string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // Linear formula on the segment from point a to point b, truncating toward zero.
    function automatic int segment_value(int a, int b, int s, output bit flat);
        int x1, x2, y1, y2;
        x1 = int'(cal_volt[a]);
        x2 = int'(cal_volt[b]);
        y1 = int'(cal_temp[a]);
        y2 = int'(cal_temp[b]);
        if (x1 == x2)
        begin
            flat = 1'b1;
            return y1;
        end
        flat = 1'b0;
        return y1 + ((y2 - y1) * (s - x1)) / (x2 - x1);
    endfunction

    // Expected temperature for one convert of the given table.
    function automatic temp_result_t predict_temperature(logic [TSEL_W-1:0] tsel,
                                                         logic [VOLT_W-1:0] sample);
        temp_result_t r;
        int n, base, s, v, i;
        bit found, flat;
        r.temp   = '0;
        r.status = STAT_NONE;
        r.sat    = 1'b0;
        if (tsel == TSEL_UNUSED)
            return r;
        n = int'(cal_count[tsel]);
        if (n < 2)
            n = 2;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        base  = int'(tsel) * MAX_POINTS;
        s     = int'(sample);
        v     = 0;
        found = 1'b0;
        flat  = 1'b0;
        // The first segment that contains the sample wins.
        for (i = 0; i + 1 < n && !found; i++)
        begin
            if (s >= int'(cal_volt[base + i]) && s <= int'(cal_volt[base + i + 1]))
            begin
                v = segment_value(base + i, base + i + 1, s, flat);
                r.status = flat ? STAT_ZERO : STAT_INTERP;
                found = 1'b1;
            end
        end
        // Outside the table, extend the end segments.
        if (!found)
        begin
            if (s < int'(cal_volt[base]))
            begin
                v = segment_value(base, base + 1, s, flat);
                r.status = flat ? STAT_ZERO : STAT_EXT_LO;
            end
            else if (s > int'(cal_volt[base + n - 1]))
            begin
                v = segment_value(base + n - 2, base + n - 1, s, flat);
                r.status = flat ? STAT_ZERO : STAT_EXT_HI;
            end
            else
            begin
                v = 0;
                r.status = STAT_NONE;
            end
        end
        if (v > 32767)
        begin
            v = 32767;
            r.sat = 1'b1;
        end
        else if (v < -32768)
        begin
            v = -32768;
            r.sat = 1'b1;
        end
        r.temp = v[TEMP_W-1:0];
        return r;
    endfunction

    function automatic cal_request_t make_load(logic [TSEL_W-1:0] tsel, logic [PIDX_W-1:0] idx,
                                               logic [VOLT_W-1:0] volt,
                                               logic signed [TEMP_W-1:0] temp);
        cal_request_t it;
        it.kind   = REQ_LOAD;
        it.tsel   = tsel;
        it.idx    = idx;
        it.volt   = volt;
        it.temp   = temp;
        it.sample = VOLT_W'($urandom);
        return it;
    endfunction

    function automatic cal_request_t make_convert(logic [TSEL_W-1:0] tsel,
                                                  logic [VOLT_W-1:0] sample);
        cal_request_t it;
        it.kind   = REQ_CONVERT;
        it.tsel   = tsel;
        it.idx    = PIDX_W'($urandom);
        it.volt   = VOLT_W'($urandom);
        it.temp   = TEMP_W'($urandom);
        it.sample = sample;
        return it;
    endfunction

    function automatic logic [CFG_W-1:0] random_point_count();
        case ($urandom_range(0, 7))
            0:       return CFG_W'(2);
            1:       return CFG_W'(MAX_POINTS);
            2:       return CFG_W'($urandom_range(0, 1));
            3:       return CFG_W'($urandom_range(MAX_POINTS + 1, 31));
            default: return CFG_W'($urandom_range(2, MAX_POINTS));
        endcase
    endfunction

    // Offer one request after a random gap and update the shadow state once it is accepted.
    task automatic send_request(cal_request_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.req_type          <= it.kind;
        req_ch.table_select      <= it.tsel;
        req_ch.point_index       <= it.idx;
        req_ch.point_voltage     <= it.volt;
        req_ch.point_temperature <= it.temp;
        req_ch.raw_sample        <= it.sample;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (it.kind == REQ_LOAD)
        begin
            if (it.tsel != TSEL_UNUSED)
            begin
                cal_volt[int'(it.tsel) * MAX_POINTS + int'(it.idx)] = it.volt;
                cal_temp[int'(it.tsel) * MAX_POINTS + int'(it.idx)] = it.temp;
            end
        end
        else
        begin
            pending_temps.push_back(predict_temperature(it.tsel, it.sample));
        end
    endtask

    // Stop offering requests and wait until the block has gone quiet.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cal_count[idx] = value;
    endtask

    // Load a fresh set of sixteen points into one table.
    task automatic load_table(logic [TSEL_W-1:0] tsel, table_layout_t layout);
        int volts [MAX_POINTS];
        int j, k, key, v;
        v = $urandom_range(0, 4095 - 64);
        for (j = 0; j < MAX_POINTS; j++)
        begin
            case (layout)
                LAYOUT_SORTED:
                    volts[j] = (j > 0 && $urandom_range(0, 9) == 0) ? volts[j-1]
                                                                    : $urandom_range(0, 4095);
                LAYOUT_STEEP:
                begin
                    v += $urandom_range(0, 4);
                    volts[j] = v;
                end
                default:
                    volts[j] = $urandom_range(0, 4095);
            endcase
        end
        // Sorted tables keep any repeated voltages next to each other.
        if (layout == LAYOUT_SORTED)
        begin
            for (j = 1; j < MAX_POINTS; j++)
            begin
                key = volts[j];
                k = j - 1;
                while (k >= 0 && volts[k] > key)
                begin
                    volts[k+1] = volts[k];
                    k--;
                end
                volts[k+1] = key;
            end
        end
        for (j = 0; j < MAX_POINTS; j++)
            send_request(make_load(tsel, PIDX_W'(j), VOLT_W'(volts[j]), TEMP_W'($urandom)));
    endtask

    // Known contents for all three tables, so that no convert reads an empty point.
    task automatic test_table_fill();
        int t, i, v, y;
        for (t = 0; t < NUM_TABLES; t++)
        begin
            for (i = 0; i < MAX_POINTS; i++)
            begin
                case (t)
                    0:
                    begin
                        v = 200 + 200 * i;
                        y = -8000 + 1000 * i;
                    end
                    1:
                    begin
                        if (i == 0)
                        begin
                            v = 2000;
                            y = -32768;
                        end
                        else if (i == 1)
                        begin
                            v = 2001;
                            y = 32767;
                        end
                        else if (i == MAX_POINTS - 1)
                        begin
                            v = 4095;
                            y = 0;
                        end
                        else
                        begin
                            v = 2001 + (i - 1) * 100;
                            y = 32767 - 3000 * i;
                        end
                    end
                    default:
                    begin
                        if (i < 2)
                        begin
                            v = 1000;
                            y = 5000 - 1000 * i;
                        end
                        else if (i < MAX_POINTS - 2)
                        begin
                            v = 1000 + (i - 1) * 200;
                            y = 5000 - 1500 * i;
                        end
                        else
                        begin
                            v = 3900;
                            y = -20000 - 5000 * (i - (MAX_POINTS - 2));
                        end
                    end
                endcase
                send_request(make_load(TSEL_W'(t), PIDX_W'(i), VOLT_W'(v), TEMP_W'(y)));
            end
        end
    endtask

    // Extremes, every status, saturation both ways and the unused table select.
    task automatic test_directed_cases();
        // Reset point counts still in force.
        send_request(make_convert(TSEL_WATER, 12'd300));
        settle_block();
        write_count(CFG_WATER, CFG_W'(MAX_POINTS));
        write_count(CFG_FLAME, CFG_W'(2));
        write_count(CFG_OVERTEMP, CFG_W'(MAX_POINTS));

        send_request(make_convert(TSEL_WATER, 12'd0));
        send_request(make_convert(TSEL_WATER, 12'd4095));
        send_request(make_convert(TSEL_WATER, 12'd200));
        send_request(make_convert(TSEL_WATER, 12'd3200));
        send_request(make_convert(TSEL_WATER, 12'd1234));

        // Steep flame segment drives both extrapolations into saturation.
        send_request(make_convert(TSEL_FLAME, 12'd0));
        send_request(make_convert(TSEL_FLAME, 12'd4095));
        send_request(make_convert(TSEL_FLAME, 12'd2000));
        send_request(make_convert(TSEL_FLAME, 12'd2001));

        // Zero-width segments at both ends and a falling slope that truncates.
        send_request(make_convert(TSEL_OVERTEMP, 12'd500));
        send_request(make_convert(TSEL_OVERTEMP, 12'd1000));
        send_request(make_convert(TSEL_OVERTEMP, 12'd1333));
        send_request(make_convert(TSEL_OVERTEMP, 12'd4000));
        send_request(make_convert(TSEL_OVERTEMP, 12'd3900));

        // The unused table select answers with no segment and ignores loads.
        send_request(make_convert(TSEL_UNUSED, 12'd4095));
        send_request(make_load(TSEL_UNUSED, 4'd15, 12'd4095, 16'sh7fff));
        send_request(make_convert(TSEL_UNUSED, 12'd0));

        // Points at the edges of the voltage and temperature ranges.
        send_request(make_load(TSEL_WATER, 4'd0, 12'd0, 16'sh8000));
        send_request(make_convert(TSEL_WATER, 12'd0));
        send_request(make_load(TSEL_OVERTEMP, 4'd15, 12'd4095, 16'sh7fff));
        send_request(make_convert(TSEL_OVERTEMP, 12'd4095));
        settle_block();
    endtask

    // The result side holds off for a long stretch while converts keep coming.
    task automatic test_output_backpressure();
        int k;
        send_idle_pct = 0;
        hold_off_seq++;
        for (k = 0; k < 12; k++)
        begin
            if (k % 4 == 3)
                send_request(make_load(TSEL_WATER, PIDX_W'($urandom), VOLT_W'($urandom),
                                       TEMP_W'($urandom)));
            else
                send_request(make_convert(TSEL_W'($urandom_range(0, 2)), VOLT_W'($urandom)));
        end
        settle_block();
    endtask

    // Rounds of count changes, table reloads, stray loads and bursts of converts.
    task automatic test_random_traffic(int item_budget, int send_pct, int recv_pct);
        int sent, k, n_conv, base;
        logic [TSEL_W-1:0] tsel;
        logic [VOLT_W-1:0] sample;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < item_budget)
        begin
            settle_block();
            if ($urandom_range(0, 2) != 0)
                write_count(CFG_WATER, random_point_count());
            if ($urandom_range(0, 2) != 0)
                write_count(CFG_FLAME, random_point_count());
            if ($urandom_range(0, 2) != 0)
                write_count(CFG_OVERTEMP, random_point_count());

            if ($urandom_range(0, 2) == 0)
            begin
                load_table(TSEL_W'($urandom_range(0, 2)), table_layout_t'($urandom_range(0, 2)));
                sent += MAX_POINTS;
            end

            // Stray single-point loads, some to the unused select.
            repeat ($urandom_range(0, 2))
            begin
                tsel = TSEL_W'($urandom);
                send_request(make_load(tsel, PIDX_W'($urandom), VOLT_W'($urandom),
                                       TEMP_W'($urandom)));
                if (tsel != TSEL_UNUSED)
                    sent++;
            end

            n_conv = $urandom_range(10, 30);
            for (k = 0; k < n_conv; k++)
            begin
                tsel = ($urandom_range(0, 31) == 0) ? TSEL_UNUSED
                                                    : TSEL_W'($urandom_range(0, 2));
                base = int'(tsel) * MAX_POINTS + $urandom_range(0, MAX_POINTS - 1);
                case ($urandom_range(0, 9))
                    0:       sample = '0;
                    1:       sample = '1;
                    2, 3:    sample = (tsel == TSEL_UNUSED) ? VOLT_W'($urandom) : cal_volt[base];
                    4:       sample = (tsel == TSEL_UNUSED) ? VOLT_W'($urandom)
                                    : cal_volt[base] + VOLT_W'($urandom_range(0, 1) ? 1 : -1);
                    default: sample = VOLT_W'($urandom);
                endcase
                send_request(make_convert(tsel, sample));
            end
            sent += n_conv;
        end
        settle_block();
    endtask

    // Result side: random stalls, long hold-off on request, and the check of each transaction.
    initial
    begin
        temp_result_t want;
        int hold_left;
        int seen_seq;
        res_ch.ready <= 1'b0;
        hold_left = 0;
        seen_seq  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (res_ch.valid && res_ch.ready)
                begin
                    if (pending_temps.size() == 0)
                    begin
                        flag_mismatch($sformatf("unexpected result temperature %0d status %0d",
                                                res_ch.temperature, res_ch.status));
                    end
                    else
                    begin
                        want = pending_temps.pop_front();
                        if (res_ch.temperature !== want.temp)
                            flag_mismatch($sformatf("temperature %0d, expected %0d",
                                                    res_ch.temperature, want.temp));
                        if (res_ch.status !== want.status)
                            flag_mismatch($sformatf("status %0d, expected %0d",
                                                    res_ch.status, want.status));
                        if (res_ch.saturated !== want.sat)
                            flag_mismatch($sformatf("saturated %0b, expected %0b",
                                                    res_ch.saturated, want.sat));
                    end
                end
                if (hold_off_seq != seen_seq)
                begin
                    seen_seq  = hold_off_seq;
                    hold_left = HOLD_OFF_CYCLES;
                end
                if (hold_left > 0)
                begin
                    res_ch.ready <= 1'b0;
                    hold_left--;
                end
                else
                begin
                    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        int drain_wait;
        rst_n                    <= 1'b0;
        req_ch.valid             <= 1'b0;
        req_ch.req_type          <= REQ_LOAD;
        req_ch.table_select      <= TSEL_WATER;
        req_ch.point_index       <= '0;
        req_ch.point_voltage     <= '0;
        req_ch.point_temperature <= '0;
        req_ch.raw_sample        <= '0;
        cfg_wr_en                <= 1'b0;
        cfg_index                <= CFG_WATER;
        cfg_data                 <= '0;
        cal_count[CFG_WATER]     = CFG_W'(2);
        cal_count[CFG_FLAME]     = CFG_W'(2);
        cal_count[CFG_OVERTEMP]  = CFG_W'(2);
        hold_off_seq   = 0;
        mismatch_count = 0;
        send_idle_pct  = 38;
        recv_stall_pct = 62;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_directed_cases();
        test_output_backpressure();
        test_random_traffic(600, 38, 62);
        test_random_traffic(600, 62, 38);
        test_random_traffic(500, 0, 0);

        // Drain what is left, with a bound.
        for (drain_wait = 0; drain_wait < DRAIN_LIMIT && pending_temps.size() != 0;
             drain_wait++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_temps.size() != 0)
            flag_mismatch($sformatf("%0d conversions never returned", pending_temps.size()));

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
